// ===== hw/rtl/lifo_stack_with_max_query_assert.svh =====
// Assertion macros shared by the stack checker.
`ifndef LIFO_STACK_WITH_MAX_QUERY_ASSERT_SVH
`define LIFO_STACK_WITH_MAX_QUERY_ASSERT_SVH

// Clocked assertion, disabled while reset is held; expects clk and arst_n in scope.
`define LSMQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication that must hold in the cycle after the trigger.
`define LSMQ_ASSERT_NEXT(lbl, trig, cons, msg) \
	`LSMQ_ASSERT(lbl, (trig) |=> (cons), msg)

`endif

// ===== hw/rtl/lsmq_pkg.sv =====
// Package: command, status and sequencer types for the stack with max query.
package lsmq_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned CNT_OUT_W = 7;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_PEEK = 2'd2,
		CMD_MAX  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_FINISH
	} state_t;

endpackage

// ===== hw/rtl/lsmq_req_if.sv =====
// Request channel: command and push value with valid/ready handshake.
interface lsmq_req_if
	import lsmq_pkg::*;
;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	word_t       push_value;

	modport source (output valid, output command, output push_value, input ready);
	modport sink   (input valid, input command, input push_value, output ready);
endinterface

// ===== hw/rtl/lsmq_rsp_if.sv =====
// Response channel: result word, status and fill count with valid/ready handshake.
interface lsmq_rsp_if
	import lsmq_pkg::*;
;
	logic                 valid;
	logic                 ready;
	word_t                result_value;
	logic [1:0]           status;
	logic [CNT_OUT_W-1:0] count_after;

	modport source (output valid, output result_value, output status, output count_after,
		input ready);
	modport sink   (input valid, input result_value, input status, input count_after,
		output ready);
endinterface

// ===== hw/rtl/lsmq_ram.sv =====
// Entry store: single write port, single registered read port.
module lsmq_ram
	import lsmq_pkg::*;
#(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  word_t         wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output word_t         rdata
);

	word_t mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/lifo_stack_with_max_query.sv =====
// Bounded LIFO stack of signed 32-bit words with push, pop, peek and a max scan over all
// held entries. The block takes one transaction at a time: req.ready is high only while
// the sequencer is idle. A push, or any command that ends in status empty or full, goes
// straight from acceptance to the final step; pop and peek pass through a read step first,
// and max then goes on to scan the lower entries, walking the single read port of the entry
// store one entry per cycle from top to bottom through one shared signed comparator. A
// finished result sits in the output register, and the block waits in its final step only
// while that register still holds an untaken result. No clearing pass is needed after reset.
module lifo_stack_with_max_query
	import lsmq_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	lsmq_req_if.sink      req,
	lsmq_rsp_if.source    rsp
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	state_t               state_q, state_d;
	logic [CW-1:0]        count_q;
	cmd_t                 cmd_q;
	status_t              st_q;
	logic [AW-1:0]        addr_q;
	word_t                acc_q;

	logic                 rsp_vld_q;
	word_t                rsp_val_q;
	status_t              rsp_st_q;
	logic [CNT_OUT_W-1:0] rsp_cnt_q;

	logic                 accept;
	cmd_t                 req_cmd;
	logic                 is_push;
	logic                 full;
	logic                 empty;
	logic [CW-1:0]        cnt_dec;
	logic [AW-1:0]        addr_dec;
	logic                 last;
	logic                 take_max;
	logic                 out_load;

	logic                 mem_we;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	word_t                rd_word;

	// entry store
	lsmq_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (count_q[AW-1:0]),
		.wdata (req.push_value),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_word)
	);

	// decode and shared compare
	assign accept   = req.valid && req.ready;
	assign req_cmd  = cmd_t'(req.command);
	assign is_push  = (req_cmd == CMD_PUSH);
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign cnt_dec  = count_q - 1'b1;
	assign addr_dec = addr_q - 1'b1;
	assign last     = (addr_q == '0);
	assign take_max = (rd_word > acc_q);
	assign out_load = (state_q == S_FINISH) && (!rsp_vld_q || rsp.ready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (is_push || empty) ? S_FINISH : S_READ;
				end
			end
			S_READ: begin
				state_d = ((cmd_q != CMD_MAX) || last) ? S_FINISH : S_SCAN;
			end
			S_SCAN: begin
				if (last) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = addr_dec;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				mem_we    = accept && is_push && !full;
				mem_re    = accept && !is_push && !empty;
				mem_raddr = cnt_dec[AW-1:0];
			end
			S_READ: begin
				mem_re = (cmd_q == CMD_MAX) && !last;
			end
			S_SCAN: begin
				mem_re = !last;
			end
			S_FINISH: begin
				mem_re = 1'b0;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (is_push && !full) begin
					count_q <= count_q + 1'b1;
				end else if ((req_cmd == CMD_POP) && !empty) begin
					count_q <= cnt_dec;
				end
			end
		end
	end

	// working registers: command, status, scan pointer, running result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q  <= req_cmd;
					addr_q <= cnt_dec[AW-1:0];
					acc_q  <= '0;
					if (is_push) begin
						st_q <= full ? ST_FULL : ST_OK;
					end else begin
						st_q <= empty ? ST_EMPTY : ST_OK;
					end
				end
			end
			S_READ: begin
				acc_q <= rd_word;
				if (mem_re) begin
					addr_q <= addr_dec;
				end
			end
			S_SCAN: begin
				if (take_max) begin
					acc_q <= rd_word;
				end
				if (mem_re) begin
					addr_q <= addr_dec;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (out_load) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_val_q <= acc_q;
			rsp_st_q  <= st_q;
			rsp_cnt_q <= CNT_OUT_W'(count_q);
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.result_value = rsp_val_q;
	assign rsp.status       = rsp_st_q;
	assign rsp.count_after  = rsp_cnt_q;

endmodule

// ===== hw/rtl/lsmq_chk.sv =====
// Port-level checker for the stack with max query, bound to the top level.
`include "lifo_stack_with_max_query_assert.svh"

module lsmq_chk
	import lsmq_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input word_t                rsp_result_value,
	input logic [1:0]           rsp_status,
	input logic [CNT_OUT_W-1:0] rsp_count_after
);

	// full is only reported with the stack at capacity
	`LSMQ_ASSERT(a_full_count, (rsp_valid && (rsp_status == ST_FULL)) |-> (rsp_count_after == CNT_OUT_W'(DEPTH)), "full status with stack not at capacity")

	// empty results carry zero word and zero count
	`LSMQ_ASSERT(a_empty_zero, (rsp_valid && (rsp_status == ST_EMPTY)) |-> ((rsp_count_after == '0) && (rsp_result_value == '0)), "empty status with nonzero word or count")

	// one transaction at a time: busy right after acceptance
	`LSMQ_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "request accepted while previous still in work")

	// a stalled result holds
	`LSMQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_value) && $stable(rsp_status) && $stable(rsp_count_after), "stalled result changed")

endmodule

bind lifo_stack_with_max_query lsmq_chk #(
	.DEPTH (DEPTH)
) u_lsmq_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_result_value (rsp.result_value),
	.rsp_status       (rsp.status),
	.rsp_count_after  (rsp.count_after)
);
